// ----- design/bmul_pkg.sv -----
// Package with shared constants and types for the radix-2 Booth multiplier.
`timescale 1ns / 1ps
`default_nettype none
package bmul_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int CODE_W    = 2;

  localparam logic [CODE_W-1:0] CODE_TWOS     = 2'd0;
  localparam logic [CODE_W-1:0] CODE_SIGN_MAG = 2'd1;
  localparam logic [CODE_W-1:0] CODE_ONES     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bmul_state_t;

endpackage
`default_nettype wire

// ----- design/bmul_in_if.sv -----
// Input channel interface carrying two tagged operands.
`timescale 1ns / 1ps
`default_nettype none
interface bmul_in_if #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [WIDTH-1:0]       multiplicand;
  logic signed [WIDTH-1:0]       multiplier;
  logic [bmul_pkg::CODE_W-1:0]   a_code;
  logic [bmul_pkg::CODE_W-1:0]   b_code;

  modport source (output valid, output multiplicand, output multiplier,
                  output a_code, output b_code, input ready);
  modport sink (input valid, input multiplicand, input multiplier,
                input a_code, input b_code, output ready);
endinterface
`default_nettype wire

// ----- design/bmul_out_if.sv -----
// Result channel interface carrying the product.
`timescale 1ns / 1ps
`default_nettype none
interface bmul_out_if #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [2*WIDTH-2:0] product;

  modport source (output valid, output product, input ready);
  modport sink (input valid, input product, output ready);
endinterface
`default_nettype wire

// ----- design/booth_radix2_multiplier.sv -----
// Top level of the radix-2 Booth multiplier with tagged operand encodings.
// Each item carries two WIDTH-bit operands, each tagged as two's complement,
// sign-magnitude or ones' complement (an unused tag reads as two's complement),
// and yields one (2*WIDTH-1)-bit two's complement product that wraps when both
// operands are the most negative value. The Booth unit retires one multiplier
// bit per cycle with a single WIDTH+1-bit adder (the last step waits while an
// earlier product is unaccepted) and takes an item only when idle. The product
// sits in an output register, so the next item can be taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module booth_radix2_multiplier #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmul_in_if.sink    in_if,
  bmul_out_if.source out_if
);
  import bmul_pkg::*;

  logic [WIDTH-1:0]   a_tc;
  logic [WIDTH-1:0]   b_tc;
  logic               idle;
  logic               start;
  logic [2*WIDTH-2:0] product;

  bmul_conv #(.WIDTH(WIDTH)) u_conv_a (
    .pattern (in_if.multiplicand),
    .code    (in_if.a_code),
    .twos    (a_tc)
  );

  bmul_conv #(.WIDTH(WIDTH)) u_conv_b (
    .pattern (in_if.multiplier),
    .code    (in_if.b_code),
    .twos    (b_tc)
  );

  assign in_if.ready = idle;
  assign start       = in_if.valid && idle;

  bmul_core #(.WIDTH(WIDTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .a_tc      (a_tc),
    .b_tc      (b_tc),
    .idle      (idle),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .product   (product)
  );

  assign out_if.product = product;

endmodule
`default_nettype wire

// ----- design/bmul_conv.sv -----
// Converter from a tagged operand encoding to two's complement.
`timescale 1ns / 1ps
`default_nettype none
module bmul_conv #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEF
) (
  input  wire logic [WIDTH-1:0]            pattern,
  input  wire logic [bmul_pkg::CODE_W-1:0] code,
  output logic      [WIDTH-1:0]            twos
);
  import bmul_pkg::*;

  logic [WIDTH-1:0] mag;
  logic [WIDTH-1:0] base;
  logic             inc;

  assign mag = {1'b0, pattern[WIDTH-2:0]};

  // Negative sign-magnitude or ones' complement values are negated from the
  // magnitude or bumped by one; both negative zero patterns end up at zero.
  always_comb begin
    base = pattern;
    inc  = 1'b0;
    if (pattern[WIDTH-1]) begin
      unique case (code)
        CODE_SIGN_MAG: begin
          base = ~mag;
          inc  = 1'b1;
        end
        CODE_ONES: begin
          base = pattern;
          inc  = 1'b1;
        end
        default: begin
          base = pattern;
          inc  = 1'b0;
        end
      endcase
    end
  end

  assign twos = base + {{(WIDTH-1){1'b0}}, inc};

endmodule
`default_nettype wire

// ----- design/bmul_core.sv -----
// Iterative radix-2 Booth unit with a shifting multiplier register and result register.
`timescale 1ns / 1ps
`default_nettype none
module bmul_core #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WIDTH-1:0]     a_tc,
  input  wire logic [WIDTH-1:0]     b_tc,
  output logic                      idle,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic      [2*WIDTH-2:0]   product
);
  import bmul_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  bmul_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [WIDTH:0]     p_r;
  logic [WIDTH-1:0]   q_r;
  logic               q1_r;
  logic [WIDTH-1:0]   a_r;
  logic [2*WIDTH-2:0] prod_r;
  logic               oval_r;

  logic               last;
  logic               step_en;
  logic               load_out;
  logic [WIDTH:0]     a_ext;
  logic [WIDTH:0]     sum;

  assign last  = (cnt_r == CNT_LAST);
  assign a_ext = {a_r[WIDTH-1], a_r};

  always_comb begin
    unique case ({q_r[0], q1_r})
      2'b01:   sum = p_r + a_ext;
      2'b10:   sum = p_r - a_ext;
      default: sum = p_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last && (!oval_r || out_ready)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle     = 1'b0;
    step_en  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: idle = 1'b1;
      ST_RUN: begin
        step_en  = !last;
        load_out = last && (!oval_r || out_ready);
      end
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (step_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (load_out) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  // The final step skips the shift: the product is the unshifted partial
  // product above the multiplier bits that remain.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a_tc;
      p_r  <= '0;
      q_r  <= b_tc;
      q1_r <= 1'b0;
    end else if (step_en) begin
      p_r  <= {sum[WIDTH], sum[WIDTH:1]};
      q_r  <= {sum[0], q_r[WIDTH-1:1]};
      q1_r <= q_r[0];
    end
    if (load_out) begin
      prod_r <= {sum[WIDTH-1:0], q_r[WIDTH-1:1]};
    end
  end

  assign out_valid = oval_r;
  assign product   = prod_r;

endmodule
`default_nettype wire

// ----- dv/booth_radix2_multiplier_test.sv -----
// Self-checking testbench for the radix-2 Booth multiplier with tagged operand encodings.
`timescale 1ns / 1ps
module booth_radix2_multiplier_test;
  import bmul_pkg::*;

  localparam int OP_W = WIDTH_DEF;
  localparam int PROD_W = 2 * OP_W - 1;
  localparam logic [CODE_W-1:0] CODE_SPARE = 2'd3;
  localparam logic [OP_W-1:0] MOST_NEG = {1'b1, {(OP_W-1){1'b0}}};
  localparam logic [OP_W-1:0] MOST_POS = {1'b0, {(OP_W-1){1'b1}}};
  localparam logic [OP_W-1:0] ALL_ONES = {OP_W{1'b1}};
  localparam int RANDOM_ITEMS = 1450;

  typedef struct {
    logic [OP_W-1:0]   multiplicand;
    logic [OP_W-1:0]   multiplier;
    logic [CODE_W-1:0] a_code;
    logic [CODE_W-1:0] b_code;
    bit                wait_drain;
  } operand_pair_t;

  typedef struct {
    logic [PROD_W-1:0] product;
    operand_pair_t     operands;
  } product_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bmul_in_if #(.WIDTH(OP_W)) in_ch ();
  bmul_out_if #(.WIDTH(OP_W)) out_ch ();

  booth_radix2_multiplier #(.WIDTH(OP_W)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  operand_pair_t   operand_q[$];
  product_expect_t product_q[$];
  operand_pair_t   driven_pair;
  int items_total = 0;
  int items_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reads a tagged pattern as a two's complement value; negative zero maps to zero.
  function automatic logic signed [OP_W-1:0] decode_operand(logic [OP_W-1:0] pattern,
                                                            logic [CODE_W-1:0] code);
    logic [OP_W-1:0] magnitude;
    magnitude = {1'b0, pattern[OP_W-2:0]};
    if (!pattern[OP_W-1]) return pattern;
    case (code)
      CODE_SIGN_MAG: return -magnitude;
      CODE_ONES:     return pattern + 1'b1;
      default:       return pattern;
    endcase
  endfunction

  function automatic logic [PROD_W-1:0] booth_product(operand_pair_t pair);
    logic signed [OP_W-1:0]   a;
    logic signed [OP_W-1:0]   b;
    logic signed [2*OP_W-1:0] full;
    a = decode_operand(pair.multiplicand, pair.a_code);
    b = decode_operand(pair.multiplier, pair.b_code);
    full = a * b;
    return full[PROD_W-1:0];
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    if (r < 97) return $urandom_range(7, 20);
    return $urandom_range(30, 60);
  endfunction

  function automatic bit calm_window();
    return (cycle_count % 2000) < 300;
  endfunction

  function automatic logic [OP_W-1:0] random_operand();
    logic [OP_W-1:0] pick;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: pick = MOST_NEG;
          1: pick = MOST_POS;
          2: pick = '0;
          3: pick = ALL_ONES;
          4: pick = MOST_NEG + 1'b1;
          default: pick = OP_W'(1);
        endcase
      end
      1, 2: begin
        pick = OP_W'($urandom_range(0, 15));
        pick[OP_W-1] = 1'($urandom_range(0, 1));
      end
      3: pick = ALL_ONES - OP_W'($urandom_range(0, 15));
      default: pick = OP_W'($urandom);
    endcase
    return pick;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CODE_SPARE;
    case (r % 3)
      0: return CODE_TWOS;
      1: return CODE_SIGN_MAG;
      default: return CODE_ONES;
    endcase
  endfunction

  task automatic add_pair(logic [OP_W-1:0] a, logic [OP_W-1:0] b,
                          logic [CODE_W-1:0] ac, logic [CODE_W-1:0] bc, bit drain);
    operand_pair_t pair;
    pair.multiplicand = a;
    pair.multiplier = b;
    pair.a_code = ac;
    pair.b_code = bc;
    pair.wait_drain = drain;
    operand_q.push_back(pair);
    items_total++;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.multiplicand = '0;
    in_ch.multiplier = '0;
    in_ch.a_code = CODE_TWOS;
    in_ch.b_code = CODE_TWOS;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Driver: presents pending items and records the expected product at each accept.
  always @(posedge clk) begin
    product_expect_t want;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want.product = booth_product(driven_pair);
        want.operands = driven_pair;
        product_q.push_back(want);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (operand_q.size() != 0 && operand_q[0].wait_drain &&
                     product_q.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else if (operand_q.size() != 0) begin
          driven_pair = operand_q.pop_front();
          in_ch.multiplicand <= driven_pair.multiplicand;
          in_ch.multiplier <= driven_pair.multiplier;
          in_ch.a_code <= driven_pair.a_code;
          in_ch.b_code <= driven_pair.b_code;
          in_ch.valid <= 1'b1;
          gap_left = (calm_window() || $urandom_range(0, 99) < 45) ? 0 : pick_idle();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each product against the oldest expectation and stalls at random.
  always @(posedge clk) begin
    product_expect_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (product_q.size() == 0) begin
          $display("%0t: unexpected product, expected none actual %0d", $time,
                   $signed(out_ch.product));
          error_count++;
        end else begin
          want = product_q.pop_front();
          if (out_ch.product !== want.product) begin
            $display("%0t: product mismatch, expected %0d actual %0d (a=%h/%0d b=%h/%0d)",
                     $time, $signed(want.product), $signed(out_ch.product),
                     want.operands.multiplicand, want.operands.a_code,
                     want.operands.multiplier, want.operands.b_code);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm_window() && $urandom_range(0, 5) == 0) begin
        stall_left = pick_idle() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    add_pair(MOST_POS, MOST_POS, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair(MOST_NEG, MOST_NEG, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair(MOST_NEG, MOST_POS, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair('0, MOST_NEG, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair(ALL_ONES, ALL_ONES, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair(16'h0001, MOST_NEG, CODE_TWOS, CODE_TWOS, 1'b0);
    add_pair(MOST_NEG, 16'h1234, CODE_SIGN_MAG, CODE_TWOS, 1'b0);
    add_pair(ALL_ONES, MOST_POS, CODE_SIGN_MAG, CODE_SIGN_MAG, 1'b0);
    add_pair(16'h8001, 16'h8001, CODE_SIGN_MAG, CODE_SIGN_MAG, 1'b0);
    add_pair(16'h1234, MOST_NEG, CODE_TWOS, CODE_SIGN_MAG, 1'b0);
    add_pair(ALL_ONES, MOST_NEG, CODE_ONES, CODE_TWOS, 1'b0);
    add_pair(MOST_NEG, MOST_NEG, CODE_ONES, CODE_ONES, 1'b0);
    add_pair(16'hFFFE, MOST_POS, CODE_ONES, CODE_TWOS, 1'b0);
    add_pair(MOST_POS, ALL_ONES, CODE_TWOS, CODE_ONES, 1'b0);
    add_pair(16'h8005, 16'hFFFA, CODE_SIGN_MAG, CODE_ONES, 1'b0);
    add_pair(MOST_NEG, MOST_NEG, CODE_SPARE, CODE_SPARE, 1'b0);
    add_pair(ALL_ONES, 16'h8001, CODE_SPARE, CODE_SIGN_MAG, 1'b0);
    add_pair(MOST_POS, MOST_POS, CODE_SIGN_MAG, CODE_ONES, 1'b0);
    add_pair(16'h5555, 16'hAAAA, CODE_ONES, CODE_SPARE, 1'b0);
    add_pair(16'hAAAA, 16'h5555, CODE_SIGN_MAG, CODE_TWOS, 1'b0);
    add_pair('0, '0, CODE_ONES, CODE_SIGN_MAG, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_pair(random_operand(), random_operand(), random_code(), random_code(),
               (i % 300) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total) @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
